>>> sv/ppr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers of the vertex projection pipeline.
package ppr_pkg;

    // Fixed-point format of coordinates and factors
    localparam int FRAC_BITS  = 13;
    localparam int NEAR_FLOOR = ((1 << FRAC_BITS) + 50) / 100;
    // Orthographic divisor base: pixel denominator 2^(2F+1) split as base << (F+2)
    localparam int ORTHO_BASE = 1 << (FRAC_BITS - 1);

    // Divider geometry: non-negative dividend, divisor, quotient bits
    localparam int DIV_NW  = 63;
    localparam int DIV_DW  = 32;
    localparam int DIV_QB  = DIV_DW - 1;
    localparam int DIV_LAT = DIV_QB + 1;

    localparam int FRONT_LAT = 3;
    localparam int BACK_LAT  = 4;
    localparam int PIPE_LAT  = FRONT_LAT + DIV_LAT + BACK_LAT + DIV_LAT + 1;

    // Projection modes
    localparam logic [1:0] MODE_ORTHO  = 2'd0;
    localparam logic [1:0] MODE_PERSP3 = 2'd1;
    localparam logic [1:0] MODE_PERSP4 = 2'd2;

    // Register indexes
    localparam logic [2:0] CFG_MODE   = 3'd0;
    localparam logic [2:0] CFG_WIDTH  = 3'd1;
    localparam logic [2:0] CFG_HEIGHT = 3'd2;
    localparam logic [2:0] CFG_OSCALE = 3'd3;
    localparam logic [2:0] CFG_CAMD   = 3'd4;
    localparam logic [2:0] CFG_FOC3   = 3'd5;
    localparam logic [2:0] CFG_HYPD   = 3'd6;
    localparam logic [2:0] CFG_FOC4   = 3'd7;

    typedef struct packed {
        logic [1:0]  mode;
        logic [12:0] width;
        logic [12:0] height;
        logic [14:0] ortho_scale;
        logic [15:0] cam_dist;
        logic [15:0] focal3;
        logic [15:0] hyper_dist;
        logic [15:0] focal4;
    } t_cfg;

    // Request data carried alongside the 4D divide
    typedef struct packed {
        logic [1:0]         mode;
        logic               near4;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_fside;

    // Divider operands: magnitude form of a floor division
    typedef struct packed {
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
        logic              neg;
    } t_divreq;

    // Floor of n/d for signed n: divide ~n when negative and invert the quotient
    function automatic t_divreq to_req(input logic signed [DIV_NW-1:0] n,
                                       input logic [DIV_DW-1:0] d);
        t_divreq r;
        r.neg = n[DIV_NW-1];
        r.num = r.neg ? ~n : n;
        r.den = d;
        return r;
    endfunction

endpackage

>>> sv/ppr_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, saturating.
module ppr_div
    import ppr_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  t_divreq                  i_req,
    output logic signed [DIV_DW-1:0] o_quo
);

    logic [DIV_NW-1:0] r_rem [0:DIV_QB];
    logic [DIV_DW-1:0] r_den [0:DIV_QB];
    logic [DIV_QB-1:0] r_quo [0:DIV_QB];
    logic              r_neg [0:DIV_QB];
    logic              r_ovf [0:DIV_QB];
    logic [DIV_NW-1:0] w_lim;
    logic [DIV_QB-1:0] w_mag;

    // Flag quotients that do not fit the quotient bits
    assign w_lim = DIV_NW'(i_req.den) << DIV_QB;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_req.num;
            r_den[0] <= i_req.den;
            r_quo[0] <= '0;
            r_neg[0] <= i_req.neg;
            r_ovf[0] <= (i_req.num >= w_lim);
        end
    end

    // One trial subtract per stage, most significant quotient bit first
    for (genvar k = 1; k <= DIV_QB; k++) begin : g_step
        logic [DIV_NW-1:0] w_sub;
        logic              w_ge;

        assign w_sub = DIV_NW'(r_den[k-1]) << (DIV_QB - k);
        assign w_ge  = (r_rem[k-1] >= w_sub);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? (r_rem[k-1] - w_sub) : r_rem[k-1];
                r_quo[k] <= r_quo[k-1] | (w_ge ? (DIV_QB'(1) << (DIV_QB - k)) : '0);
                r_den[k] <= r_den[k-1];
                r_neg[k] <= r_neg[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    // Saturate the magnitude, then restore the floor sign
    assign w_mag = r_ovf[DIV_QB] ? '1 : r_quo[DIV_QB];
    assign o_quo = r_neg[DIV_QB] ? ~{1'b0, w_mag} : {1'b0, w_mag};

endmodule

>>> sv/ppr_front.sv
`timescale 1ns / 1ps
// 4D depth offset, products and divide operands for the 4D-to-3D step.
module ppr_front
    import ppr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  t_cfg               i_cfg,
    input  logic signed [15:0] i_x,
    input  logic signed [15:0] i_y,
    input  logic signed [15:0] i_z,
    input  logic signed [15:0] i_w,
    output t_fside             o_side,
    output t_divreq            o_req_x,
    output t_divreq            o_req_y,
    output t_divreq            o_req_z
);

    logic signed [17:0] w_off;
    logic               w_near;
    logic signed [32:0] w_xf, w_yf, w_zf;
    logic signed [45:0] w_ax;
    logic [29:0]        w_dd;
    logic signed [33:0] w_ny, w_nz;
    logic signed [47:0] w_nx;

    logic [16:0]        r1_off;
    logic [12:0]        r1_wdiv;
    logic signed [31:0] r1_xf, r1_yf, r1_zf;
    t_fside             r1_side;

    logic signed [45:0] r2_ax;
    logic [29:0]        r2_dd;
    logic signed [33:0] r2_ny, r2_nz;
    logic [17:0]        r2_doff;
    t_fside             r2_side;

    // Stage 1: offset w, floor it, scale coordinates by the 4D focal factor
    assign w_off  = {{2{i_w[15]}}, i_w} + $signed({2'b00, i_cfg.hyper_dist});
    assign w_near = (w_off < $signed(18'(NEAR_FLOOR)));
    assign w_xf   = i_x * $signed({1'b0, i_cfg.focal4});
    assign w_yf   = i_y * $signed({1'b0, i_cfg.focal4});
    assign w_zf   = i_z * $signed({1'b0, i_cfg.focal4});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_off        <= w_near ? 17'(NEAR_FLOOR) : w_off[16:0];
            r1_wdiv       <= (i_cfg.width == '0) ? 13'd1 : i_cfg.width;
            r1_xf         <= w_xf[31:0];
            r1_yf         <= w_yf[31:0];
            r1_zf         <= w_zf[31:0];
            r1_side.mode  <= i_cfg.mode;
            r1_side.near4 <= w_near;
            r1_side.x     <= i_x;
            r1_side.y     <= i_y;
            r1_side.z     <= i_z;
        end
    end

    // Stage 2: aspect product, divisor and rounding numerators of y and z
    assign w_ax = r1_xf * $signed({1'b0, i_cfg.height});
    assign w_dd = r1_wdiv * r1_off;
    assign w_ny = $signed({r1_yf[31], r1_yf, 1'b0}) + $signed({17'b0, r1_off});
    assign w_nz = $signed({r1_zf[31], r1_zf, 1'b0}) + $signed({17'b0, r1_off});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_ax   <= w_ax;
            r2_dd   <= w_dd;
            r2_ny   <= w_ny;
            r2_nz   <= w_nz;
            r2_doff <= {r1_off, 1'b0};
            r2_side <= r1_side;
        end
    end

    // Stage 3: round half up as floor((2a + d) / 2d)
    assign w_nx = $signed({r2_ax[45], r2_ax, 1'b0}) + $signed({18'b0, r2_dd});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_req_x <= to_req(DIV_NW'(w_nx), DIV_DW'({r2_dd, 1'b0}));
            o_req_y <= to_req(DIV_NW'(r2_ny), DIV_DW'(r2_doff));
            o_req_z <= to_req(DIV_NW'(r2_nz), DIV_DW'(r2_doff));
            o_side  <= r2_side;
        end
    end

endmodule

>>> sv/ppr_back.sv
`timescale 1ns / 1ps
// 3D depth offset, pixel numerators and divide operands for both screen axes.
module ppr_back
    import ppr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  t_cfg               i_cfg,
    input  t_fside             i_side,
    input  logic signed [31:0] i_qx,
    input  logic signed [31:0] i_qy,
    input  logic signed [31:0] i_qz,
    output t_divreq            o_req_x,
    output t_divreq            o_req_y,
    output logic               o_near
);

    logic               w_p4;
    logic               w_ortho;
    logic signed [32:0] w_off;
    logic               w_c3;
    logic [15:0]        w_k;
    logic signed [47:0] w_pfx, w_pfy;
    logic [12:0]        w_mx;
    logic [13:0]        w_wp1, w_hp1;
    logic signed [60:0] w_ax, w_ay;
    logic [45:0]        w_bw, w_bh;
    logic signed [DIV_NW-1:0] w_nx, w_ay2, w_ny;

    logic [1:0]         r1_mode;
    logic               r1_near4;
    logic signed [31:0] r1_x3, r1_y3, r1_z3;

    logic signed [47:0] r2_pfx, r2_pfy;
    logic [31:0]        r2_base;
    logic               r2_ortho, r2_near;

    logic signed [60:0] r3_ax, r3_ay;
    logic [45:0]        r3_bw, r3_bh;
    logic [31:0]        r3_base;
    logic               r3_ortho, r3_near;

    // Stage 1: pick the 3D point, projected from 4D or taken as given
    assign w_p4 = (i_side.mode == MODE_PERSP4);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_x3    <= w_p4 ? i_qx : 32'(i_side.x);
            r1_y3    <= w_p4 ? i_qy : 32'(i_side.y);
            r1_z3    <= w_p4 ? i_qz : 32'(i_side.z);
            r1_mode  <= i_side.mode;
            r1_near4 <= i_side.near4;
        end
    end

    // Stage 2: offset z, floor it, first product with focal or scale factor
    assign w_ortho = (r1_mode != MODE_PERSP3) && (r1_mode != MODE_PERSP4);
    assign w_off   = 33'(r1_z3) + $signed({17'b0, i_cfg.cam_dist});
    assign w_c3    = (w_off < $signed(33'(NEAR_FLOOR)));
    assign w_k     = w_ortho ? {1'b0, i_cfg.ortho_scale} : i_cfg.focal3;
    assign w_pfx   = r1_x3 * $signed({1'b0, w_k});
    assign w_pfy   = r1_y3 * $signed({1'b0, w_k});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_pfx   <= w_pfx;
            r2_pfy   <= w_pfy;
            r2_ortho <= w_ortho;
            if (w_ortho) begin
                r2_base <= 32'(ORTHO_BASE);
            end else if (w_c3) begin
                r2_base <= 32'(NEAR_FLOOR);
            end else begin
                r2_base <= w_off[31:0];
            end
            r2_near  <= ((r1_mode == MODE_PERSP3) && w_c3) ||
                        ((r1_mode == MODE_PERSP4) && (r1_near4 || w_c3));
        end
    end

    // Stage 3: second products and screen-centre terms
    assign w_mx  = r2_ortho ? i_cfg.width : i_cfg.height;
    assign w_wp1 = 14'(i_cfg.width) + 14'd1;
    assign w_hp1 = 14'(i_cfg.height) + 14'd1;
    assign w_ax  = r2_pfx * $signed({1'b0, w_mx});
    assign w_ay  = r2_pfy * $signed({1'b0, i_cfg.height});
    assign w_bw  = r2_base * w_wp1;
    assign w_bh  = r2_base * w_hp1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_ax    <= w_ax;
            r3_ay    <= w_ay;
            r3_bw    <= w_bw;
            r3_bh    <= w_bh;
            r3_base  <= r2_base;
            r3_ortho <= r2_ortho;
            r3_near  <= r2_near;
        end
    end

    // Stage 4: pixel numerator 2a + base*(dim+1)*2^(F+1); flip y in perspective
    assign w_nx  = $signed({r3_ax[60], r3_ax, 1'b0}) +
                   $signed({3'b000, r3_bw, (FRAC_BITS + 1)'(0)});
    assign w_ay2 = $signed({r3_ay[60], r3_ay, 1'b0});
    assign w_ny  = (r3_ortho ? w_ay2 : -w_ay2) +
                   $signed({3'b000, r3_bh, (FRAC_BITS + 1)'(0)});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_req_x <= to_req(w_nx >>> (FRAC_BITS + 2), r3_base);
            o_req_y <= to_req(w_ny >>> (FRAC_BITS + 2), r3_base);
            o_near  <= r3_near;
        end
    end

endmodule

>>> sv/vertex_perspective_projection.sv
`timescale 1ns / 1ps
// Vertex projection top level: configuration, pipeline control, output stage.
//
// Maps one point (x, y, z, w in signed Q2.13) to a rounded, saturated screen
// pixel in orthographic, 3D perspective or 4D-then-3D perspective mode. The
// block takes one request per clock while the pipeline is not halted; most
// of its pipeline depth lies in two 31-step restoring dividers in series
// (the 4D depth divide and the 3D pixel divide), each one bit per
// stage. The whole pipeline advances together: it halts only while a result
// waits at the output and the sink is not ready. Write configuration only
// while no request is in flight.
module vertex_perspective_projection
    import ppr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    // Input point
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // coord_x, coord_y, coord_z, coord_w
    // Output pixel
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata    // screen_x, screen_y, near_clamped, zero pad
);

    t_cfg               r_cfg;
    logic [PIPE_LAT-1:0] r_vld;
    logic               w_en;

    t_fside             w_fside;
    t_divreq            w_rq4x, w_rq4y, w_rq4z;
    logic signed [31:0] w_q4x, w_q4y, w_q4z;
    t_fside             r_fdly [0:DIV_LAT-1];

    t_divreq            w_rq3x, w_rq3y;
    logic               w_bnear;
    logic signed [31:0] w_q3x, w_q3y;
    logic               r_ndly [0:DIV_LAT-1];

    logic signed [15:0] r_sx, r_sy;
    logic               r_near;

    function automatic logic signed [15:0] sat16(input logic signed [31:0] q);
        logic signed [15:0] s;
        if (q > 32'sd32767) begin
            s = 16'sh7FFF;
        end else if (q < -32'sd32768) begin
            s = 16'sh8000;
        end else begin
            s = q[15:0];
        end
        return s;
    endfunction

    // Hold configuration; write at the given index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode        <= MODE_ORTHO;
            r_cfg.width       <= 13'd800;
            r_cfg.height      <= 13'd800;
            r_cfg.ortho_scale <= 15'd4096;
            r_cfg.cam_dist    <= 16'd12288;
            r_cfg.focal3      <= 16'd8192;
            r_cfg.hyper_dist  <= 16'd12288;
            r_cfg.focal4      <= 16'd8192;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MODE:   r_cfg.mode        <= i_cfg_wdata[1:0];
                CFG_WIDTH:  r_cfg.width       <= i_cfg_wdata[12:0];
                CFG_HEIGHT: r_cfg.height      <= i_cfg_wdata[12:0];
                CFG_OSCALE: r_cfg.ortho_scale <= i_cfg_wdata[14:0];
                CFG_CAMD:   r_cfg.cam_dist    <= i_cfg_wdata;
                CFG_FOC3:   r_cfg.focal3      <= i_cfg_wdata;
                CFG_HYPD:   r_cfg.hyper_dist  <= i_cfg_wdata;
                CFG_FOC4:   r_cfg.focal4      <= i_cfg_wdata;
            endcase
        end
    end

    // Advance the whole pipeline unless a result is held at the output
    assign w_en       = !r_vld[PIPE_LAT-1] || i_m_tready;
    assign o_s_tready = w_en && i_rst_n;
    assign o_m_tvalid = r_vld[PIPE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_s_tvalid};
        end
    end

    ppr_front u_front (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_x     (i_s_tdata[15:0]),
        .i_y     (i_s_tdata[31:16]),
        .i_z     (i_s_tdata[47:32]),
        .i_w     (i_s_tdata[63:48]),
        .o_side  (w_fside),
        .o_req_x (w_rq4x),
        .o_req_y (w_rq4y),
        .o_req_z (w_rq4z)
    );

    ppr_div u_div4x (.i_clk(i_clk), .i_en(w_en), .i_req(w_rq4x), .o_quo(w_q4x));
    ppr_div u_div4y (.i_clk(i_clk), .i_en(w_en), .i_req(w_rq4y), .o_quo(w_q4y));
    ppr_div u_div4z (.i_clk(i_clk), .i_en(w_en), .i_req(w_rq4z), .o_quo(w_q4z));

    // Carry the original point and 4D floor flag beside the 4D divide
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fdly[0] <= w_fside;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_fdly[i] <= r_fdly[i-1];
            end
        end
    end

    ppr_back u_back (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_side  (r_fdly[DIV_LAT-1]),
        .i_qx    (w_q4x),
        .i_qy    (w_q4y),
        .i_qz    (w_q4z),
        .o_req_x (w_rq3x),
        .o_req_y (w_rq3y),
        .o_near  (w_bnear)
    );

    ppr_div u_div3x (.i_clk(i_clk), .i_en(w_en), .i_req(w_rq3x), .o_quo(w_q3x));
    ppr_div u_div3y (.i_clk(i_clk), .i_en(w_en), .i_req(w_rq3y), .o_quo(w_q3y));

    // Carry the near flag beside the pixel divide
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ndly[0] <= w_bnear;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_ndly[i] <= r_ndly[i-1];
            end
        end
    end

    // Saturate pixels into the output register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sx   <= sat16(w_q3x);
            r_sy   <= sat16(w_q3y);
            r_near <= r_ndly[DIV_LAT-1];
        end
    end

    assign o_m_tdata = {7'b0, r_near, r_sy, r_sx};

`ifndef SYNTHESIS
    // Requests in flight change only by those taken in and handed out
    a_vld_count: assert property (@(posedge i_clk)
        (i_rst_n && $past(i_rst_n)) |->
            ($countones(r_vld) == $past($countones(r_vld)) +
                $past(i_s_tvalid && o_s_tready) - $past(o_m_tvalid && i_m_tready)))
        else $error("pipeline valid count out of step with handshakes");

    // Pad bits of a presented result stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[39:33] == 7'b0))
        else $error("output pad bits not zero");

    // A held result keeps its pixel values
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> $stable(r_sx) && $stable(r_sy) && $stable(r_near))
        else $error("held result changed");
`endif

endmodule

>>> test/vertex_perspective_projection_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the vertex projection block: directed and random points, all modes.
module vertex_perspective_projection_tb;
    import ppr_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic               near;
    } t_pixel;

    // Scoreboard: projects each accepted point and checks results in order
    class pixel_scoreboard;
        t_pixel pending[$];
        logic [1:0]  mode = MODE_ORTHO;
        logic [12:0] width = 800, height = 800;
        logic [14:0] oscale = 4096;
        logic [15:0] camd = 12288, foc3 = 8192, hypd = 12288, foc4 = 8192;
        int mismatches = 0;
        int checked = 0;

        function void set_reg(logic [2:0] idx, logic [15:0] v);
            case (idx)
                CFG_MODE:   mode = v[1:0];
                CFG_WIDTH:  width = v[12:0];
                CFG_HEIGHT: height = v[12:0];
                CFG_OSCALE: oscale = v[14:0];
                CFG_CAMD:   camd = v;
                CFG_FOC3:   foc3 = v;
                CFG_HYPD:   hypd = v;
                default:    foc4 = v;
            endcase
        endfunction

        function longint fdiv(longint a, longint d, output longint r);
            longint q;
            q = a / d;
            r = a % d;
            if (r < 0) begin
                q -= 1;
                r += d;
            end
            return q;
        endfunction

        function longint rdiv(longint a, longint d);
            longint r;
            return fdiv(2 * a + d, 2 * d, r);
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function longint to_pixel(longint a, longint d, longint dim);
            longint r, q, p;
            q = fdiv(a, d, r);
            if (dim[0])
                p = (dim + 1) / 2 + q;
            else
                p = dim / 2 + q + ((2 * r >= d) ? 1 : 0);
            return clip(p, -32768, 32767);
        endfunction

        function logic depth3(longint x, longint y, longint z, output longint px,
                              output longint py);
            longint w, h, off, d;
            logic near;
            w = width;
            h = height;
            off = z + longint'(camd);
            near = 1'b0;
            if (off < NEAR_FLOOR) begin
                off = NEAR_FLOOR;
                near = 1'b1;
            end
            d = (2 * off) <<< FRAC_BITS;
            px = to_pixel(x * foc3 * h, d, w);
            py = to_pixel(-y * foc3 * h, d, h);
            return near;
        endfunction

        function void note_point(logic [63:0] data);
            longint x, y, z, wc, w, h, px, py, off, wd, x3, y3, z3;
            t_pixel e;
            x = longint'($signed(data[15:0]));
            y = longint'($signed(data[31:16]));
            z = longint'($signed(data[47:32]));
            wc = longint'($signed(data[63:48]));
            w = width;
            h = height;
            e.near = 1'b0;
            if (mode == MODE_PERSP3) begin
                e.near = depth3(x, y, z, px, py);
            end else if (mode == MODE_PERSP4) begin
                off = wc + longint'(hypd);
                wd = (w == 0) ? 1 : w;
                if (off < NEAR_FLOOR) begin
                    off = NEAR_FLOOR;
                    e.near = 1'b1;
                end
                x3 = clip(rdiv(x * foc4 * h, wd * off), -64'sd2147483648, 64'sd2147483647);
                y3 = clip(rdiv(y * foc4, off), -64'sd2147483648, 64'sd2147483647);
                z3 = clip(rdiv(z * foc4, off), -64'sd2147483648, 64'sd2147483647);
                if (depth3(x3, y3, z3, px, py))
                    e.near = 1'b1;
            end else begin
                px = to_pixel(x * oscale * w, 64'sd1 <<< (2 * FRAC_BITS), w);
                py = to_pixel(y * oscale * h, 64'sd1 <<< (2 * FRAC_BITS), h);
            end
            e.sx = px[15:0];
            e.sy = py[15:0];
            pending.push_back(e);
        endfunction

        function void check_pixel(logic [39:0] data);
            t_pixel e;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel %h at %0t", data, $realtime);
                return;
            end
            e = pending.pop_front();
            if (data[15:0] !== e.sx || data[31:16] !== e.sy || data[32] !== e.near) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("pixel mismatch: expected x=%0d y=%0d near=%0b, got x=%0d y=%0d near=%0b",
                             e.sx, e.sy, e.near, $signed(data[15:0]),
                             $signed(data[31:16]), data[32]);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_addr = '0;
    logic [15:0] i_cfg_wdata = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;

    pixel_scoreboard board = new();
    int  cycles = 0;
    int  points_sent = 0;
    bit  sink_hold = 1'b0;
    bit  sink_random = 1'b0;

    vertex_perspective_projection uut (.*);

    always #5 i_clk = ~i_clk;

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("vertex_perspective_projection verification failed");
            $finish;
        end
    end

    // Note accepted requests and check results at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready)
            board.note_point(i_s_tdata);
        if (i_rst_n && o_m_tvalid && i_m_tready)
            board.check_pixel(o_m_tdata);
    end

    // Sink: random stalls, mostly short, or a long hold-off on request
    initial begin
        int gap;
        forever begin
            @(negedge i_clk);
            if (sink_hold) begin
                i_m_tready <= 1'b0;
            end else if (sink_random && $urandom_range(0, 3) == 0) begin
                gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                                   : $urandom_range(1, 3);
                i_m_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 16384) - 8192);
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one point and hold it until accepted, with optional idle gap
    task automatic send_point(logic [63:0] data, bit idle);
        int gap;
        if (idle && $urandom_range(0, 3) == 0) begin
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                               : $urandom_range(1, 3);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= data;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        points_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (PIPE_LAT + 8) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        board.set_reg(idx, v);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_setting(logic [1:0] mode, bit extreme);
        write_reg(CFG_MODE, 16'(mode));
        if (extreme) begin
            write_reg(CFG_WIDTH, $urandom_range(0, 1) ? 16'd4096 : 16'($urandom_range(0, 1)));
            write_reg(CFG_HEIGHT, $urandom_range(0, 1) ? 16'd4096 : 16'($urandom_range(0, 1)));
            write_reg(CFG_OSCALE, $urandom_range(0, 1) ? 16'h7fff : 16'h0000);
            write_reg(CFG_CAMD, $urandom_range(0, 1) ? 16'hffff : 16'h0000);
            write_reg(CFG_FOC3, $urandom_range(0, 1) ? 16'hffff : 16'h0000);
            write_reg(CFG_HYPD, $urandom_range(0, 1) ? 16'hffff : 16'h0000);
            write_reg(CFG_FOC4, $urandom_range(0, 1) ? 16'hffff : 16'h0000);
        end else begin
            write_reg(CFG_WIDTH, 16'($urandom_range(1, 4096)));
            write_reg(CFG_HEIGHT, 16'($urandom_range(1, 4096)));
            write_reg(CFG_OSCALE, 16'($urandom_range(0, 32767)));
            write_reg(CFG_CAMD, 16'($urandom_range(0, 65535)));
            write_reg(CFG_FOC3, 16'($urandom_range(0, 65535)));
            write_reg(CFG_HYPD, 16'($urandom_range(0, 65535)));
            write_reg(CFG_FOC4, 16'($urandom_range(0, 65535)));
        end
    endtask

    initial begin
        logic [15:0] cx, cy, cz, cw;
        logic [1:0]  md;
        int hold;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset setting, field extremes and depth floor cases per mode
        for (int m = 0; m < 4; m++) begin
            if (m > 0) begin
                drain();
                write_reg(CFG_MODE, 16'(m));
            end
            send_point({16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff}, 1'b0);
            send_point({16'h8000, 16'h8000, 16'h8000, 16'h8000}, 1'b0);
            send_point({16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0);
            // depth offset just under, at and over 0.01
            send_point({16'($signed(NEAR_FLOOR - 12288 - 1)), 16'($signed(NEAR_FLOOR - 12288 - 1)),
                        16'h1000, 16'hf000}, 1'b0);
            send_point({16'($signed(NEAR_FLOOR - 12288)), 16'($signed(NEAR_FLOOR - 12288)),
                        16'h2000, 16'he000}, 1'b0);
            send_point({16'($signed(NEAR_FLOOR - 12288 + 1)),
                        16'($signed(NEAR_FLOOR - 12288 + 1)), 16'h0fff, 16'h8001}, 1'b0);
        end
        drain();

        // Random phases over many settings; one phase stalls the sink for long
        for (int phase = 0; phase < 24; phase++) begin
            md = (phase % 8 == 7) ? 2'd3 : 2'(phase % 3);
            random_setting(md, phase % 4 == 3);
            sink_random = (phase % 5 != 1);
            if (phase == 2) begin
                sink_hold = 1'b1;
                fork
                    begin
                        hold = 0;
                        while (hold < 300) begin
                            @(posedge i_clk);
                            hold++;
                        end
                        sink_hold = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < 80; n++) begin
                cx = pick_coord();
                cy = pick_coord();
                cz = pick_coord();
                cw = pick_coord();
                send_point({cw, cz, cy, cx}, phase % 5 != 1);
            end
            drain();
        end

        $display("covered %0d points over 24 register settings in all modes,", points_sent);
        $display("%0d results checked, %0d mismatches", board.checked, board.mismatches);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("vertex_perspective_projection verification clean");
        else
            $display("vertex_perspective_projection verification failed");
        $finish;
    end
endmodule

>>> vertex_perspective_projection.f
sv/ppr_pkg.sv
sv/ppr_div.sv
sv/ppr_front.sv
sv/ppr_back.sv
sv/vertex_perspective_projection.sv
test/vertex_perspective_projection_tb.sv
